// ===== sv/hpa_pkg.sv =====
// Shared types and default sizes for the handle pool allocator.
// No dependencies; used by handle_pool_allocator_core.
package hpa_pkg;

    localparam int MAX_IDS_DEF    = 64;
    localparam int WORD_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        MODE_ADD       = 3'd0,
        MODE_REMOVE    = 3'd1,
        MODE_REM_FIRST = 3'd2,
        MODE_GET       = 3'd3,
        MODE_SET       = 3'd4,
        MODE_CLEAR     = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

endpackage

// ===== sv/hpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced by handle_pool_allocator_core.
module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/handle_pool_allocator_core.sv =====
// Handle pool allocator: LIFO free stack, swap-remove active list, per-id words.
// Depends on hpa_pkg and hpa_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command word: mode, handle_id,
//   resource_word, info_word. Output channel (out_valid/out_ready) returns one
//   result word per command: status, result_id, resource_out, info_out, plus
//   high_water, first_active and active_total as they stand after the command.
//   Commands run one at a time on a small sequencer around four RAMs
//   (word store, free stack, active list, id-to-position map), each with one
//   write and one registered read per cycle.
//   Sequence: add, remove, remove-first and get pass S_EXEC (RAM read), then
//   a write/capture state, then S_DONE; set, clear, unused modes and rejected
//   commands go from S_EXEC straight to S_DONE. out_valid and in_ready both
//   return when S_DONE loads the output register.
//   A finished word sits in the output register; the next command may be
//   accepted while it waits. If the receiver stalls, the sequencer holds in
//   its final state until the output register frees up.
//   Reset: empty pool, high_water 1, no active ids, output register empty.
//   The words of id 0 read as zero until id 0 is set.
module handle_pool_allocator_core #(
    parameter int MAX_IDS    = hpa_pkg::MAX_IDS_DEF,
    parameter int WORD_WIDTH = hpa_pkg::WORD_WIDTH_DEF,
    localparam int ID_W = $clog2(MAX_IDS),
    localparam int HW_W = ID_W + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [ID_W-1:0]       handle_id,
    input  logic [WORD_WIDTH-1:0] resource_word,
    input  logic [WORD_WIDTH-1:0] info_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [ID_W-1:0]       result_id,
    output logic [WORD_WIDTH-1:0] resource_out,
    output logic [WORD_WIDTH-1:0] info_out,
    output logic [HW_W-1:0]       high_water,
    output logic [ID_W-1:0]       first_active,
    output logic [ID_W-1:0]       active_total
);

    localparam int DW = 2 * WORD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD_WR,
        S_RM_WR,
        S_GET_RD,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              mode_reg, mode_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [WORD_WIDTH-1:0]   rw_reg, rw_next;
    logic [WORD_WIDTH-1:0]   iw_reg, iw_next;
    logic                    pop_reg, pop_next;
    logic                    slot0_set_reg, slot0_set_next;

    hpa_pkg::status_t        st_reg, st_next;
    logic [ID_W-1:0]         rid_reg, rid_next;
    logic [WORD_WIDTH-1:0]   rout_reg, rout_next;
    logic [WORD_WIDTH-1:0]   iout_reg, iout_next;

    logic [ID_W-1:0]         free_depth_reg, free_depth_next;
    logic [ID_W-1:0]         active_depth_reg, active_depth_next;
    logic [HW_W-1:0]         fresh_reg, fresh_next;
    logic [MAX_IDS-1:0]      active_flags_reg, active_flags_next;
    logic [ID_W-1:0]         head_reg, head_next;

    logic                    out_valid_reg, out_valid_next;
    hpa_pkg::status_t        out_status_reg, out_status_next;
    logic [ID_W-1:0]         out_rid_reg, out_rid_next;
    logic [WORD_WIDTH-1:0]   out_rout_reg, out_rout_next;
    logic [WORD_WIDTH-1:0]   out_iout_reg, out_iout_next;
    logic [HW_W-1:0]         out_hw_reg, out_hw_next;
    logic [ID_W-1:0]         out_first_reg, out_first_next;
    logic [ID_W-1:0]         out_total_reg, out_total_next;

    // RAM ports
    logic                    data_we, data_re;
    logic [ID_W-1:0]         data_waddr, data_raddr;
    logic [DW-1:0]           data_wdata, data_rdata;
    logic                    fs_we, fs_re;
    logic [ID_W-1:0]         fs_waddr, fs_raddr, fs_wdata, fs_rdata;
    logic                    al_we, al_re;
    logic [ID_W-1:0]         al_waddr, al_raddr, al_wdata, al_rdata;
    logic                    pos_we, pos_re;
    logic [ID_W-1:0]         pos_waddr, pos_raddr, pos_wdata, pos_rdata;

    logic                    id_in_range;
    logic [ID_W-1:0]         add_id;

    hpa_ram #(.WIDTH(DW), .DEPTH(MAX_IDS)) u_data_ram (
        .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
        .re(data_re), .raddr(data_raddr), .rdata(data_rdata)
    );

    hpa_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_free_ram (
        .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .re(fs_re), .raddr(fs_raddr), .rdata(fs_rdata)
    );

    hpa_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_active_ram (
        .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
        .re(al_re), .raddr(al_raddr), .rdata(al_rdata)
    );

    hpa_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_pos_ram (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_id    = out_rid_reg;
    assign resource_out = out_rout_reg;
    assign info_out     = out_iout_reg;
    assign high_water   = out_hw_reg;
    assign first_active = out_first_reg;
    assign active_total = out_total_reg;

    assign id_in_range = ({1'b0, id_reg} < fresh_reg);
    assign add_id      = pop_reg ? fs_rdata : fresh_reg[ID_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        id_next           = id_reg;
        rw_next           = rw_reg;
        iw_next           = iw_reg;
        pop_next          = pop_reg;
        slot0_set_next    = slot0_set_reg;
        st_next           = st_reg;
        rid_next          = rid_reg;
        rout_next         = rout_reg;
        iout_next         = iout_reg;
        free_depth_next   = free_depth_reg;
        active_depth_next = active_depth_reg;
        fresh_next        = fresh_reg;
        active_flags_next = active_flags_reg;
        head_next         = head_reg;
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_rid_next      = out_rid_reg;
        out_rout_next     = out_rout_reg;
        out_iout_next     = out_iout_reg;
        out_hw_next       = out_hw_reg;
        out_first_next    = out_first_reg;
        out_total_next    = out_total_reg;

        data_we    = 1'b0;
        data_waddr = id_reg;
        data_wdata = '0;
        data_re    = 1'b0;
        data_raddr = id_reg;
        fs_we      = 1'b0;
        fs_waddr   = free_depth_reg;
        fs_wdata   = id_reg;
        fs_re      = 1'b0;
        fs_raddr   = free_depth_reg - 1'b1;
        al_we      = 1'b0;
        al_waddr   = active_depth_reg;
        al_wdata   = add_id;
        al_re      = 1'b0;
        al_raddr   = active_depth_reg - 1'b1;
        pos_we     = 1'b0;
        pos_waddr  = add_id;
        pos_wdata  = active_depth_reg;
        pos_re     = 1'b0;
        pos_raddr  = id_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    id_next    = handle_id;
                    rw_next    = resource_word;
                    iw_next    = info_word;
                    st_next    = hpa_pkg::ST_OK;
                    rid_next   = '0;
                    rout_next  = '0;
                    iout_next  = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    hpa_pkg::MODE_ADD:
                    begin
                        if (free_depth_reg != '0)
                        begin
                            fs_re      = 1'b1;
                            pop_next   = 1'b1;
                            state_next = S_ADD_WR;
                        end
                        else if (fresh_reg != HW_W'(MAX_IDS))
                        begin
                            pop_next   = 1'b0;
                            state_next = S_ADD_WR;
                        end
                        else
                        begin
                            st_next = hpa_pkg::ST_FULL;
                        end
                    end
                    hpa_pkg::MODE_REMOVE:
                    begin
                        if (id_reg == '0 || !id_in_range || !active_flags_reg[id_reg])
                        begin
                            st_next = hpa_pkg::ST_BAD_ID;
                        end
                        else
                        begin
                            data_re    = 1'b1;
                            pos_re     = 1'b1;
                            al_re      = 1'b1;
                            state_next = S_RM_WR;
                        end
                    end
                    hpa_pkg::MODE_REM_FIRST:
                    begin
                        if (active_depth_reg == '0)
                        begin
                            st_next = hpa_pkg::ST_EMPTY;
                        end
                        else if (!active_flags_reg[head_reg])
                        begin
                            st_next = hpa_pkg::ST_BAD_ID;
                        end
                        else
                        begin
                            id_next    = head_reg;
                            rid_next   = head_reg;
                            data_re    = 1'b1;
                            data_raddr = head_reg;
                            pos_re     = 1'b1;
                            pos_raddr  = head_reg;
                            al_re      = 1'b1;
                            state_next = S_RM_WR;
                        end
                    end
                    hpa_pkg::MODE_GET:
                    begin
                        if (id_in_range)
                        begin
                            data_re    = 1'b1;
                            state_next = S_GET_RD;
                        end
                        else
                        begin
                            st_next = hpa_pkg::ST_BAD_ID;
                        end
                    end
                    hpa_pkg::MODE_SET:
                    begin
                        if (id_in_range)
                        begin
                            data_we    = 1'b1;
                            data_wdata = {iw_reg, rw_reg};
                            if (id_reg == '0)
                            begin
                                slot0_set_next = 1'b1;
                            end
                        end
                        else
                        begin
                            st_next = hpa_pkg::ST_BAD_ID;
                        end
                    end
                    hpa_pkg::MODE_CLEAR:
                    begin
                        free_depth_next   = '0;
                        active_depth_next = '0;
                        fresh_next        = HW_W'(1);
                        active_flags_next = '0;
                        head_next         = '0;
                        data_we           = 1'b1;
                        data_waddr        = '0;
                        slot0_set_next    = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ADD_WR:
            begin
                rid_next   = add_id;
                data_we    = 1'b1;
                data_waddr = add_id;
                data_wdata = {iw_reg, rw_reg};
                al_we      = 1'b1;
                pos_we     = 1'b1;
                active_flags_next[add_id] = 1'b1;
                if (active_depth_reg == '0)
                begin
                    head_next = add_id;
                end
                active_depth_next = active_depth_reg + 1'b1;
                if (pop_reg)
                begin
                    free_depth_next = free_depth_reg - 1'b1;
                end
                else
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_RM_WR:
            begin
                rout_next  = data_rdata[WORD_WIDTH-1:0];
                data_we    = 1'b1;
                data_wdata = '0;
                // swap-remove: last entry moves into the vacated slot
                al_we      = 1'b1;
                al_waddr   = pos_rdata;
                al_wdata   = al_rdata;
                pos_we     = 1'b1;
                pos_waddr  = al_rdata;
                pos_wdata  = pos_rdata;
                fs_we      = 1'b1;
                free_depth_next   = free_depth_reg + 1'b1;
                active_depth_next = active_depth_reg - 1'b1;
                active_flags_next[id_reg] = 1'b0;
                if (pos_rdata == '0)
                begin
                    head_next = al_rdata;
                end
                state_next = S_DONE;
            end
            S_GET_RD:
            begin
                // id 0 holds zero words until first written
                if (id_reg != '0 || slot0_set_reg)
                begin
                    rout_next = data_rdata[WORD_WIDTH-1:0];
                    iout_next = data_rdata[DW-1:WORD_WIDTH];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_rid_next    = rid_reg;
                    out_rout_next   = rout_reg;
                    out_iout_next   = iout_reg;
                    out_hw_next     = fresh_reg;
                    out_first_next  = (active_depth_reg == '0) ? '0 : head_reg;
                    out_total_next  = active_depth_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= '0;
            id_reg           <= '0;
            rw_reg           <= '0;
            iw_reg           <= '0;
            pop_reg          <= 1'b0;
            slot0_set_reg    <= 1'b0;
            st_reg           <= hpa_pkg::ST_OK;
            rid_reg          <= '0;
            rout_reg         <= '0;
            iout_reg         <= '0;
            free_depth_reg   <= '0;
            active_depth_reg <= '0;
            fresh_reg        <= HW_W'(1);
            active_flags_reg <= '0;
            head_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= hpa_pkg::ST_OK;
            out_rid_reg      <= '0;
            out_rout_reg     <= '0;
            out_iout_reg     <= '0;
            out_hw_reg       <= HW_W'(1);
            out_first_reg    <= '0;
            out_total_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            id_reg           <= id_next;
            rw_reg           <= rw_next;
            iw_reg           <= iw_next;
            pop_reg          <= pop_next;
            slot0_set_reg    <= slot0_set_next;
            st_reg           <= st_next;
            rid_reg          <= rid_next;
            rout_reg         <= rout_next;
            iout_reg         <= iout_next;
            free_depth_reg   <= free_depth_next;
            active_depth_reg <= active_depth_next;
            fresh_reg        <= fresh_next;
            active_flags_reg <= active_flags_next;
            head_reg         <= head_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_rid_reg      <= out_rid_next;
            out_rout_reg     <= out_rout_next;
            out_iout_reg     <= out_iout_next;
            out_hw_reg       <= out_hw_next;
            out_first_reg    <= out_first_next;
            out_total_reg    <= out_total_next;
        end
    end

    // every created id is either free or active
    a_id_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        int'(free_depth_reg) + int'(active_depth_reg) + 1 == int'(fresh_reg))
        else $error("free plus active ids do not match high-water mark");

    a_flags_match_depth: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_flags_reg) == int'(active_depth_reg))
        else $error("active flag count differs from active list depth");

    a_reserved_id_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !active_flags_reg[0])
        else $error("reserved id 0 marked active");

    a_result_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 !in_ready)
        else $error("sequencer ready again too early");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for handle_pool_allocator_core: directed and random command words,
// predicted in order against a behavioral copy of the pool state.
// Depends on hpa_pkg and handle_pool_allocator_core.
module testbench;

    localparam int POOL_SIZE = hpa_pkg::MAX_IDS_DEF;
    localparam int ID_W = $clog2(POOL_SIZE);
    localparam int HW_W = ID_W + 1;
    localparam logic [ID_W-1:0] TOP_ID = ID_W'(POOL_SIZE - 1);
    localparam int WORD_W = hpa_pkg::WORD_WIDTH_DEF;
    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        hpa_pkg::status_t  st;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] info;
        logic [HW_W-1:0]   hw;
        logic [ID_W-1:0]   head;
        logic [ID_W-1:0]   count;
    } pool_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        mode = '0;
    logic [ID_W-1:0]   handle_id = '0;
    logic [WORD_W-1:0] resource_word = '0;
    logic [WORD_W-1:0] info_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [ID_W-1:0]   result_id;
    logic [WORD_W-1:0] resource_out;
    logic [WORD_W-1:0] info_out;
    logic [HW_W-1:0]   high_water;
    logic [ID_W-1:0]   first_active;
    logic [ID_W-1:0]   active_total;

    // pool state as the block should hold it
    logic [WORD_W-1:0] res_mem [POOL_SIZE];
    logic [WORD_W-1:0] info_mem [POOL_SIZE];
    logic [ID_W-1:0]   free_ids [POOL_SIZE];
    logic [ID_W-1:0]   act_ids [POOL_SIZE];
    bit                live [POOL_SIZE];
    int                free_cnt;
    int                act_cnt;
    int                fresh;

    pool_result_t pending[$];
    pool_result_t want;
    bit           idle_on = 1'b1;
    int           stall_left = 0;
    int           errors = 0;
    int unsigned  cycle_count = 0;

    handle_pool_allocator_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .handle_id    (handle_id),
        .resource_word(resource_word),
        .info_word    (info_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_id    (result_id),
        .resource_out (resource_out),
        .info_out     (info_out),
        .high_water   (high_water),
        .first_active (first_active),
        .active_total (active_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        return idle_on ? $urandom_range(0, 3) : 0;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'($urandom);
    endfunction

    function automatic void wipe_pool();
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            res_mem[k] = '0;
            info_mem[k] = '0;
            free_ids[k] = '0;
            act_ids[k] = '0;
            live[k] = 1'b0;
        end
        free_cnt = 0;
        act_cnt = 0;
        fresh = 1;
    endfunction

    function automatic logic [WORD_W-1:0] release_handle(input logic [ID_W-1:0] id);
        logic [WORD_W-1:0] res;
        res = res_mem[id];
        res_mem[id] = '0;
        info_mem[id] = '0;
        live[id] = 1'b0;
        free_ids[free_cnt] = id;
        free_cnt++;
        // swap-remove: last entry fills the hole
        for (int k = 0; k < act_cnt; k++)
        begin
            if (act_ids[k] == id)
            begin
                act_cnt--;
                act_ids[k] = act_ids[act_cnt];
                break;
            end
        end
        return res;
    endfunction

    function automatic pool_result_t predict_pool(input logic [2:0] op,
            input logic [ID_W-1:0] id, input logic [WORD_W-1:0] rw,
            input logic [WORD_W-1:0] iw);
        pool_result_t r;
        logic [ID_W-1:0] pick;
        r.st = hpa_pkg::ST_OK;
        r.id = '0;
        r.res = '0;
        r.info = '0;
        pick = '0;
        case (op)
            hpa_pkg::MODE_ADD:
            begin
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    pick = free_ids[free_cnt];
                end
                else if (fresh < POOL_SIZE)
                begin
                    pick = fresh[ID_W-1:0];
                    fresh++;
                end
                else
                    r.st = hpa_pkg::ST_FULL;
                if (r.st == hpa_pkg::ST_OK)
                begin
                    res_mem[pick] = rw;
                    info_mem[pick] = iw;
                    live[pick] = 1'b1;
                    act_ids[act_cnt] = pick;
                    act_cnt++;
                    r.id = pick;
                end
            end
            hpa_pkg::MODE_REMOVE:
            begin
                if (id == 0 || id >= fresh || !live[id])
                    r.st = hpa_pkg::ST_BAD_ID;
                else
                    r.res = release_handle(id);
            end
            hpa_pkg::MODE_REM_FIRST:
            begin
                if (act_cnt == 0)
                    r.st = hpa_pkg::ST_EMPTY;
                else
                begin
                    pick = act_ids[0];
                    r.id = pick;
                    r.res = release_handle(pick);
                end
            end
            hpa_pkg::MODE_GET:
            begin
                if (id >= fresh)
                    r.st = hpa_pkg::ST_BAD_ID;
                else
                begin
                    r.res = res_mem[id];
                    r.info = info_mem[id];
                end
            end
            hpa_pkg::MODE_SET:
            begin
                if (id >= fresh)
                    r.st = hpa_pkg::ST_BAD_ID;
                else
                begin
                    res_mem[id] = rw;
                    info_mem[id] = iw;
                end
            end
            hpa_pkg::MODE_CLEAR:
                wipe_pool();
            default:
                ;
        endcase
        r.hw = fresh[HW_W-1:0];
        r.head = (act_cnt > 0) ? act_ids[0] : '0;
        r.count = act_cnt[ID_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
            input logic [WORD_W-1:0] got);
        if (got !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got);
            errors++;
        end
    endfunction

    // result side: check each accepted word, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending.pop_front();
                    check_field("status", WORD_W'(want.st), WORD_W'(status));
                    check_field("result_id", WORD_W'(want.id), WORD_W'(result_id));
                    check_field("resource_out", want.res, resource_out);
                    check_field("info_out", want.info, info_out);
                    check_field("high_water", WORD_W'(want.hw), WORD_W'(high_water));
                    check_field("first_active", WORD_W'(want.head),
                        WORD_W'(first_active));
                    check_field("active_total", WORD_W'(want.count),
                        WORD_W'(active_total));
                end
                stall_left = pick_gap();
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    task automatic issue_cmd(input logic [2:0] op, input logic [ID_W-1:0] id,
            input logic [WORD_W-1:0] rw, input logic [WORD_W-1:0] iw);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        handle_id <= id;
        resource_word <= rw;
        info_word <= iw;
        do
            @(posedge clk);
        while (!in_ready);
        pending.push_back(predict_pool(op, id, rw, iw));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reserved_and_empty();
        idle_on = 1'b1;
        issue_cmd(hpa_pkg::MODE_GET, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_REM_FIRST, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_REMOVE, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_REMOVE, TOP_ID, '1, '1);
        issue_cmd(hpa_pkg::MODE_GET, ID_W'(1), '0, '0);
        issue_cmd(hpa_pkg::MODE_SET, TOP_ID, '1, '1);
        issue_cmd(MODE_SPARE_A, TOP_ID, '1, '1);
        issue_cmd(MODE_SPARE_B, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_SET, '0, '1, '0);
        issue_cmd(hpa_pkg::MODE_GET, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_SET, '0, '0, '1);
        issue_cmd(hpa_pkg::MODE_GET, '0, '0, '0);
        settle();
    endtask

    task automatic test_add_remove();
        issue_cmd(hpa_pkg::MODE_ADD, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_ADD, TOP_ID, '1, '1);
        issue_cmd(hpa_pkg::MODE_ADD, rand_id(), rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_ADD, rand_id(), rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_GET, ID_W'(1), '0, '0);
        issue_cmd(hpa_pkg::MODE_GET, ID_W'(2), '0, '0);
        issue_cmd(hpa_pkg::MODE_REMOVE, ID_W'(2), '0, '0);
        issue_cmd(hpa_pkg::MODE_REMOVE, ID_W'(2), '0, '0);
        issue_cmd(hpa_pkg::MODE_GET, ID_W'(2), '0, '0);
        issue_cmd(hpa_pkg::MODE_SET, ID_W'(2), rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_ADD, rand_id(), rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_REM_FIRST, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_REMOVE, ID_W'(1), '0, '0);
        issue_cmd(hpa_pkg::MODE_CLEAR, rand_id(), rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_GET, '0, '0, '0);
        issue_cmd(hpa_pkg::MODE_GET, ID_W'(1), '0, '0);
        settle();
    endtask

    task automatic test_fill_to_full();
        idle_on = 1'b0;
        while (fresh < POOL_SIZE || free_cnt > 0)
            issue_cmd(hpa_pkg::MODE_ADD, rand_id(), rand_word(), rand_word());
        idle_on = 1'b1;
        issue_cmd(hpa_pkg::MODE_ADD, rand_id(), '1, '1);
        issue_cmd(hpa_pkg::MODE_REMOVE, TOP_ID, '0, '0);
        issue_cmd(hpa_pkg::MODE_GET, TOP_ID, '0, '0);
        issue_cmd(hpa_pkg::MODE_ADD, '0, rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_ADD, '0, rand_word(), rand_word());
        issue_cmd(hpa_pkg::MODE_SET, TOP_ID, '1, '1);
        issue_cmd(hpa_pkg::MODE_GET, TOP_ID, '0, '0);
        issue_cmd(hpa_pkg::MODE_REM_FIRST, '0, '0, '0);
        settle();
    endtask

    task automatic test_random_traffic();
        int done;
        int phase_len;
        int add_w;
        int roll;
        logic [2:0] op;
        logic [ID_W-1:0] id;
        done = 0;
        while (done < RANDOM_WORDS)
        begin
            phase_len = $urandom_range(40, 160);
            case ($urandom_range(0, 3))
                0: add_w = 15;
                1: add_w = 40;
                2: add_w = 60;
                default: add_w = 90;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < phase_len; k++)
            begin
                roll = $urandom_range(0, 999);
                if (roll < 5)
                    op = hpa_pkg::MODE_CLEAR;
                else if (roll < 25)
                    op = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
                else if ($urandom_range(0, 99) < add_w)
                    op = hpa_pkg::MODE_ADD;
                else
                begin
                    roll = $urandom_range(0, 9);
                    if (roll < 4)
                        op = hpa_pkg::MODE_REMOVE;
                    else if (roll < 6)
                        op = hpa_pkg::MODE_REM_FIRST;
                    else if (roll < 8)
                        op = hpa_pkg::MODE_GET;
                    else
                        op = hpa_pkg::MODE_SET;
                end
                id = ID_W'($urandom_range(0, POOL_SIZE - 1));
                if (op == hpa_pkg::MODE_REMOVE && act_cnt > 0 && $urandom_range(0, 3) != 0)
                    id = act_ids[$urandom_range(0, act_cnt - 1)];
                if ((op == hpa_pkg::MODE_GET || op == hpa_pkg::MODE_SET)
                        && $urandom_range(0, 4) != 0)
                    id = ID_W'($urandom_range(0, fresh - 1));
                issue_cmd(op, id, rand_word(), rand_word());
                if (op != MODE_SPARE_A && op != MODE_SPARE_B)
                    done++;
            end
        end
        settle();
    endtask

    initial
    begin
        wipe_pool();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reserved_and_empty();
        test_add_remove();
        test_fill_to_full();
        test_random_traffic();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hpa_pkg.sv
sv/hpa_ram.sv
sv/handle_pool_allocator_core.sv
bench/testbench.sv
